// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and codes shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MaxResults = 3;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_CONTROL  = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_UNTERM   = 3'd5;

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0]               count;
    out_t [MaxResults-1:0]    res;
  } batch_t;

endpackage

`default_nettype wire

// ===== rtl/jsu_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Input register, decode state and per-byte result generation.
// ----------------------------------------------------------------------------
module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire in_t    in_data,
  output logic        batch_valid,
  input  wire logic   batch_take,
  output batch_t      batch
);

  logic        in_full;
  in_t         in_q;
  logic [1:0]  mode;
  logic [1:0]  hex_count;
  logic [15:0] code_unit;

  logic [1:0]  mode_next;
  logic [1:0]  hex_count_next;
  logic [15:0] code_unit_next;

  logic [7:0]  c;
  logic        src_end;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic [15:0] u;
  logic        advance;

  assign advance     = in_full && batch_take;
  assign in_stall    = in_full && !batch_take;
  assign batch_valid = in_full;
  assign c           = in_q.in_byte;
  assign src_end     = in_q.source_end;
  assign u           = {code_unit[11:0], hex_val};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'h00;
    unique case (c)
      8'h22:   esc_val = 8'h22;
      8'h5C:   esc_val = 8'h5C;
      8'h2F:   esc_val = 8'h2F;
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0C;
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_next      = mode;
    hex_count_next = hex_count;
    code_unit_next = code_unit;
    batch          = '0;
    unique case (mode)
      MODE_WAIT: begin
        if (!src_end && c == 8'h22) begin
          mode_next = MODE_BODY;
        end else begin
          batch.count             = 2'd1;
          batch.res[0].kind       = KIND_ERR;
          batch.res[0].error_code = ERR_NO_QUOTE;
        end
      end
      MODE_BODY: begin
        priority if (src_end) begin
          mode_next               = MODE_WAIT;
          batch.count             = 2'd1;
          batch.res[0].kind       = KIND_ERR;
          batch.res[0].error_code = ERR_UNTERM;
        end else if (c == 8'h22) begin
          mode_next         = MODE_WAIT;
          batch.count       = 2'd1;
          batch.res[0].kind = KIND_DONE;
        end else if (c == 8'h5C) begin
          mode_next = MODE_ESC;
        end else if (c < 8'h20) begin
          mode_next               = MODE_WAIT;
          batch.count             = 2'd1;
          batch.res[0].kind       = KIND_ERR;
          batch.res[0].error_code = ERR_CONTROL;
        end else begin
          batch.count             = 2'd1;
          batch.res[0].kind       = KIND_BYTE;
          batch.res[0].out_byte   = c;
        end
      end
      MODE_ESC: begin
        priority if (!src_end && c == 8'h75) begin
          mode_next      = MODE_HEX;
          hex_count_next = 2'd0;
          code_unit_next = 16'h0000;
        end else if (!src_end && esc_ok) begin
          mode_next             = MODE_BODY;
          batch.count           = 2'd1;
          batch.res[0].kind     = KIND_BYTE;
          batch.res[0].out_byte = esc_val;
        end else begin
          mode_next               = MODE_WAIT;
          batch.count             = 2'd1;
          batch.res[0].kind       = KIND_ERR;
          batch.res[0].error_code = ERR_ESCAPE;
        end
      end
      MODE_HEX: begin
        priority if (src_end || !hex_ok) begin
          mode_next               = MODE_WAIT;
          hex_count_next          = 2'd0;
          code_unit_next          = 16'h0000;
          batch.count             = 2'd1;
          batch.res[0].kind       = KIND_ERR;
          batch.res[0].error_code = ERR_HEX;
        end else if (hex_count != 2'd3) begin
          hex_count_next = hex_count + 2'd1;
          code_unit_next = u;
        end else begin
          mode_next         = MODE_BODY;
          hex_count_next    = 2'd0;
          code_unit_next    = 16'h0000;
          batch.res[0].kind = KIND_BYTE;
          batch.res[1].kind = KIND_BYTE;
          batch.res[2].kind = KIND_BYTE;
          priority if (u[15:7] == 9'd0) begin
            batch.count           = 2'd1;
            batch.res[0].out_byte = u[7:0];
          end else if (u[15:11] == 5'd0) begin
            batch.count           = 2'd2;
            batch.res[0].out_byte = {3'b110, u[10:6]};
            batch.res[1].out_byte = {2'b10, u[5:0]};
          end else begin
            batch.count           = 2'd3;
            batch.res[0].out_byte = {4'b1110, u[15:12]};
            batch.res[1].out_byte = {2'b10, u[11:6]};
            batch.res[2].out_byte = {2'b10, u[5:0]};
          end
        end
      end
    endcase
    // any return to waiting clears the escape state
    if (mode_next == MODE_WAIT) begin
      hex_count_next = 2'd0;
      code_unit_next = 16'h0000;
    end
    unique case (batch.count)
      2'd1:    batch.res[0].last = 1'b1;
      2'd2:    batch.res[1].last = 1'b1;
      2'd3:    batch.res[2].last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      mode      <= MODE_WAIT;
      hex_count <= 2'd0;
      code_unit <= 16'h0000;
    end else begin
      if (!in_full || batch_take) begin
        in_full <= in_valid;
      end
      if (advance) begin
        mode      <= mode_next;
        hex_count <= hex_count_next;
        code_unit <= code_unit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_outbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register holding up to three results, shifted out one per transaction.
// ----------------------------------------------------------------------------
module jsu_outbuf
  import jsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   batch_valid,
  output logic        batch_take,
  input  wire batch_t batch,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_t        out_data
);

  logic [1:0]            count;
  out_t [MaxResults-1:0] res;
  logic                  pop;

  assign out_valid  = count != 2'd0;
  assign out_data   = res[0];
  assign pop        = out_valid && !out_stall;
  assign batch_take = (count == 2'd0) || (count == 2'd1 && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (batch_valid && batch_take) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_valid && batch_take) begin
      res <= batch.res;
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape
// Byte-serial JSON string literal decoder with \uXXXX to UTF-8 expansion.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one source byte or an
// end-of-source mark per transaction. Output channel out_valid/out_stall/
// out_data carries decoded bytes, a finished mark or an error code, with
// last set on the final result caused by one input byte.
// An input byte passes through the input register and then the result register.
// Throughput is one byte per cycle while out_stall is low; only the fourth hex
// digit of a \u escape yields two or three results, and the result register
// sends those one per cycle, holding the input until the last is being sent.
// Opening quotes, backslashes and the first three hex digits yield nothing.
// Reset empties the input and result registers and returns the decoder to
// waiting for an opening quote. When out_stall is high the result register
// holds its contents and, once the input register is also full, in_stall
// is raised until results drain.
// ----------------------------------------------------------------------------
module json_string_unescape
  import jsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic   batch_valid;
  logic   batch_take;
  batch_t batch;

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .batch_valid (batch_valid),
    .batch_take  (batch_take),
    .batch       (batch)
  );

  jsu_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .batch_valid (batch_valid),
    .batch_take  (batch_take),
    .batch       (batch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
